/* design/hgbd_pkg.sv */
// ----------------------------------------------------------------------------
// hgbd_pkg
// Shared types and constants of the hex grid boundary distance unit.
// ----------------------------------------------------------------------------
package hgbd_pkg;

  localparam int ROWS      = 8;
  localparam int ROW_CELLS = 10;
  localparam int CELLS     = 80;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int LEN_W     = 4;
  localparam int CELL_W    = 7;
  localparam int DIST_W    = 7;

  localparam logic [3:0]  ROW_COUNT_RST   = 4'd8;
  localparam logic [31:0] ROW_LENGTHS_RST = 32'hAAAA_AAAA;

  typedef logic [ROW_CELLS-1:0] row_t;

  typedef enum logic [1:0] {
    ST_ESCAPED  = 2'd0,
    ST_BLOCKED  = 2'd1,
    ST_ENCLOSED = 2'd2,
    ST_INVALID  = 2'd3
  } status_t;

  typedef enum logic {
    REG_ROW_COUNT   = 1'b0,
    REG_ROW_LENGTHS = 1'b1
  } reg_idx_t;

endpackage

/* design/hex_grid_boundary_distance_unit.sv */
// ----------------------------------------------------------------------------
// hex_grid_boundary_distance_unit
// Breadth-first distance from a start cell to the edge of an offset hex grid.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                 Contents
//  in_      slave      in_tvalid / in_tready     start cell and barrier mask
//  out_     master     out_tvalid / out_tready   status and distance
//  cfg_     APB slave  psel, penable, pready=1   row count, row lengths
//
// IDLE accepts an item, LOAD loads the rows (as many as the row count after
// clamping), SEARCH expands one frontier level at a time (none when the start
// is invalid, blocked or on the edge), and REPORT hands the word to the
// output register, waiting while a previous word is still stalled. in_tready
// is high only while the sequencer is idle, so a finished word may sit unread
// while the next item is taken. Reset is synchronous, restoring register defaults.
module hex_grid_boundary_distance_unit
  import hgbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [6:0] start_cell, [70:7] barriers_low, [86:71] barriers_high, [87] zero
  input  logic [87:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] status, [8:2] distance, [15:9] zero
  output logic [15:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  typedef enum logic [1:0] {IDLE, LOAD, SEARCH, REPORT} state_t;

  // Configuration registers
  logic [3:0]  row_count_r;
  logic [31:0] row_lengths_r;
  reg_idx_t    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r   <= ROW_COUNT_RST;
      row_lengths_r <= ROW_LENGTHS_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_idx)
        REG_ROW_COUNT:   row_count_r   <= cfg_pwdata[3:0];
        REG_ROW_LENGTHS: row_lengths_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ROW_COUNT:   cfg_prdata = {28'd0, row_count_r};
      REG_ROW_LENGTHS: cfg_prdata = row_lengths_r;
      default:         cfg_prdata = '0;
    endcase
  end

  // Sequencer and datapath registers
  state_t                  state_r;
  logic [ROW_W-1:0]        row_r;
  logic [CELL_W-1:0]       start_r;
  logic [CELL_W-1:0]       base_r;
  logic [CELLS-1:0]        bar_r;
  logic                    found_r, sblk_r, sbnd_r;
  logic [DIST_W-1:0]       dist_r;
  status_t                 res_status_r;
  logic [DIST_W-1:0]       res_dist_r;
  logic                    out_valid_r;
  status_t                 out_status_r;
  logic [DIST_W-1:0]       out_dist_r;
  row_t                    vis_r [ROWS];
  row_t                    fr_r  [ROWS];
  row_t                    bnd_r [ROWS];

  assign in_tready  = (state_r == IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_dist_r, out_status_r};

  // Row loader: one row of the grid per cycle
  logic [3:0]        grid_rows;
  logic              last_row;
  logic [LEN_W-1:0]  len_raw, len;
  logic [ROW_CELLS:0] lmask_w;
  row_t              lmask, rowbits, bmask, onehot;
  logic [CELL_W:0]   diff;
  logic              hit_row;
  logic              found_nxt, sblk_nxt, sbnd_nxt;

  always_comb begin
    if (row_count_r == 4'd0)                grid_rows = 4'd1;
    else if (row_count_r > 4'(ROWS))        grid_rows = 4'(ROWS);
    else                                    grid_rows = row_count_r;
    last_row = ({1'b0, row_r} == grid_rows - 4'd1);
    len_raw  = row_lengths_r[{row_r, 2'b00} +: LEN_W];
    if (len_raw == '0)                      len = LEN_W'(1);
    else if (len_raw > LEN_W'(ROW_CELLS))   len = LEN_W'(ROW_CELLS);
    else                                    len = len_raw;
    lmask_w  = ((ROW_CELLS+1)'(1) << len) - (ROW_CELLS+1)'(1);
    lmask    = lmask_w[ROW_CELLS-1:0];
    rowbits  = bar_r[ROW_CELLS-1:0] & lmask;
    // First and last rows are boundary throughout; others only at their ends.
    if (row_r == '0 || last_row) bmask = lmask;
    else bmask = row_t'(1) | (row_t'(1) << (len - LEN_W'(1)));
    diff      = {1'b0, start_r} - {1'b0, base_r};
    hit_row   = !diff[CELL_W] && (diff[CELL_W-1:0] < CELL_W'(len));
    onehot    = hit_row ? (row_t'(1) << diff[3:0]) : '0;
    found_nxt = found_r | hit_row;
    sblk_nxt  = sblk_r | (|(rowbits & onehot));
    sbnd_nxt  = sbnd_r | (|(bmask & onehot));
  end

  // Expansion unit: every frontier cell reaches its six neighbors at once.
  row_t              reach   [ROWS];
  row_t              nxt_map [ROWS];
  row_t              vert;
  logic              any_nxt, hit_nxt;
  logic [DIST_W-1:0] dist_nxt;

  always_comb begin
    any_nxt = 1'b0;
    hit_nxt = 1'b0;
    for (int t = 0; t < ROWS; t++) begin
      vert = '0;
      if (t > 0)        vert = vert | fr_r[t-1];
      if (t < ROWS - 1) vert = vert | fr_r[t+1];
      // Even rows are reached from columns c and c+1 of the rows beside them,
      // odd rows from columns c-1 and c.
      if ((t % 2) == 0) reach[t] = (fr_r[t] << 1) | (fr_r[t] >> 1) | vert | (vert >> 1);
      else              reach[t] = (fr_r[t] << 1) | (fr_r[t] >> 1) | vert | (vert << 1);
      nxt_map[t] = reach[t] & ~vis_r[t];
      any_nxt    = any_nxt | (|nxt_map[t]);
      hit_nxt    = hit_nxt | (|(nxt_map[t] & bnd_r[t]));
    end
    dist_nxt = dist_r + DIST_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == REPORT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        IDLE: begin
          if (in_tvalid) begin
            start_r <= in_tdata[CELL_W-1:0];
            bar_r   <= in_tdata[86:7];
            row_r   <= '0;
            base_r  <= '0;
            found_r <= 1'b0;
            sblk_r  <= 1'b0;
            sbnd_r  <= 1'b0;
            for (int t = 0; t < ROWS; t++) begin
              vis_r[t] <= '1;
              fr_r[t]  <= '0;
            end
            state_r <= LOAD;
          end
        end
        LOAD: begin
          vis_r[row_r] <= ~lmask | rowbits | onehot;
          fr_r[row_r]  <= onehot;
          bnd_r[row_r] <= bmask;
          bar_r        <= bar_r >> len;
          base_r       <= base_r + CELL_W'(len);
          row_r        <= row_r + ROW_W'(1);
          found_r      <= found_nxt;
          sblk_r       <= sblk_nxt;
          sbnd_r       <= sbnd_nxt;
          dist_r       <= '0;
          res_dist_r   <= '0;
          if (last_row) begin
            if (!found_nxt) begin
              res_status_r <= ST_INVALID;
              state_r      <= REPORT;
            end else if (sblk_nxt) begin
              res_status_r <= ST_BLOCKED;
              state_r      <= REPORT;
            end else if (sbnd_nxt) begin
              res_status_r <= ST_ESCAPED;
              state_r      <= REPORT;
            end else begin
              state_r <= SEARCH;
            end
          end
        end
        SEARCH: begin
          dist_r <= dist_nxt;
          if (hit_nxt) begin
            res_status_r <= ST_ESCAPED;
            res_dist_r   <= dist_nxt;
            state_r      <= REPORT;
          end else if (!any_nxt || dist_nxt == DIST_W'(CELLS)) begin
            res_status_r <= ST_ENCLOSED;
            state_r      <= REPORT;
          end else begin
            for (int t = 0; t < ROWS; t++) begin
              vis_r[t] <= vis_r[t] | nxt_map[t];
              fr_r[t]  <= nxt_map[t];
            end
          end
        end
        REPORT: begin
          if (!out_valid_r || out_tready) begin
            out_status_r <= res_status_r;
            out_dist_r   <= res_dist_r;
            state_r      <= IDLE;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

endmodule

/* design/hgbd_checker.sv */
// ----------------------------------------------------------------------------
// hgbd_checker
// Port-level checks of the hex grid boundary distance unit.
// ----------------------------------------------------------------------------
module hgbd_checker
  import hgbd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // Only an escape carries a distance.
  a_dist_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != ST_ESCAPED |-> out_tdata[8:2] == '0)
    else $error("distance set on a non-escape status");

  // The padding above the distance stays zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:9] == '0)
    else $error("result padding not zero");

  // After taking a word the unit is busy loading the grid.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again before the search ran");

endmodule

bind hex_grid_boundary_distance_unit hgbd_checker u_hgbd_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for hex_grid_boundary_distance_unit. Start cells and
// barrier masks stream in under random sender gaps and receiver stalls. A
// local breadth-first search over the configured hex grid predicts each
// status and distance that the directed table does not give, and every
// result word is checked in order against what is expected of it.
// A short directed table runs first, then random words under several grid
// settings, the clamped extremes among them.
module testbench;
  import hgbd_pkg::*;

  localparam int IDLE_LIMIT  = 3000;
  localparam int TAIL_CYCLES = 120;
  localparam int PRINT_CAP   = 40;
  localparam int DIR_N       = 18;
  localparam int SETTING_N   = 10;

  localparam logic [CELLS-1:0] ALL_WALLS = {CELLS{1'b1}};
  // The six neighbors of cell 44 (row 4, column 4) in the default grid.
  localparam logic [CELLS-1:0] RING_44 = (80'd1 << 34) | (80'd1 << 35) | (80'd1 << 43) |
                                         (80'd1 << 45) | (80'd1 << 54) | (80'd1 << 55);

  typedef struct packed {
    status_t           st;
    logic [DIST_W-1:0] steps;
  } escape_t;

  typedef struct packed {
    bit                known;
    logic [CELL_W-1:0] start;
    logic [CELLS-1:0]  wall;
    status_t           st;
    logic [DIST_W-1:0] steps;
  } probe_t;

  typedef struct packed {
    logic [3:0]  rows;
    logic [31:0] lens;
    bit          rnd_lens;
    int          words;
  } grid_setting_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // [6:0] start_cell, [70:7] barriers_low, [86:71] barriers_high, [87] zero
  logic [87:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  // [1:0] status, [8:2] distance, [15:9] zero
  logic [15:0] out_tdata;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Typed result of the directed row currently on the input, if any.
  logic              cur_known;
  status_t           cur_st;
  logic [DIST_W-1:0] cur_dist;

  escape_t pending_escapes [$];

  // Register copies and the grid layout derived from them.
  logic [3:0]  row_count_sh;
  logic [31:0] row_lengths_sh;
  int grid_rows;
  int n_cells;
  int row_len  [ROWS];
  int row_base [ROWS];
  int cell_r   [CELLS];
  int cell_c   [CELLS];

  int n_errors    = 0;
  int idle_cycles = 0;
  int calm_in     = 0;
  int calm_out    = 0;
  int words_in    = 0;
  int n_settings  = 1;
  int far_dist    = 0;
  int status_seen [4] = '{0, 0, 0, 0};

  probe_t dir_tab [DIR_N] = '{
    '{1'b1, 7'd0,   80'd0,          ST_ESCAPED,  7'd0},  // start on the boundary
    '{1'b1, 7'd127, ALL_WALLS,      ST_INVALID,  7'd0},  // largest start index
    '{1'b1, 7'd80,  80'd0,          ST_INVALID,  7'd0},  // first index past the grid
    '{1'b1, 7'd79,  80'd0,          ST_ESCAPED,  7'd0},  // last cell
    '{1'b1, 7'd0,   ALL_WALLS,      ST_BLOCKED,  7'd0},
    '{1'b1, 7'd44,  ALL_WALLS,      ST_BLOCKED,  7'd0},
    '{1'b1, 7'd63,  80'd1 << 63,    ST_BLOCKED,  7'd0},  // top bit of the low mask
    '{1'b1, 7'd64,  80'd1 << 64,    ST_BLOCKED,  7'd0},  // first bit of the high mask
    '{1'b1, 7'd11,  80'd0,          ST_ESCAPED,  7'd1},
    '{1'b1, 7'd44,  RING_44,        ST_ENCLOSED, 7'd0},
    '{1'b1, 7'd22,  ~(80'd1 << 22), ST_ENCLOSED, 7'd0},
    '{1'b0, 7'd44,  80'd0,          ST_ESCAPED,  7'd0},
    '{1'b0, 7'd45,  80'd0,          ST_ESCAPED,  7'd0},
    '{1'b0, 7'd55,  80'h5555_5555_5555_5555_5555, ST_ESCAPED, 7'd0},
    '{1'b0, 7'd54,  80'hAAAA_AAAA_AAAA_AAAA_AAAA, ST_ESCAPED, 7'd0},
    '{1'b0, 7'd33,  80'hFFFF_0000_0000_0000_0000, ST_ESCAPED, 7'd0},
    '{1'b0, 7'd46,  80'h0000_0000_0FFC_0000_0000, ST_ESCAPED, 7'd0},
    '{1'b0, 7'd34,  80'h000F_F803_FE00_FF80_0000, ST_ESCAPED, 7'd0}
  };

  grid_setting_t settings [SETTING_N] = '{
    '{4'd15, 32'hFFFF_FFFF, 1'b0, 140},  // both registers beyond their clamps
    '{4'd0,  32'h0000_0000, 1'b0, 30},   // clamps up to a single cell
    '{4'd1,  32'h0000_0000, 1'b1, 40},
    '{4'd2,  32'h0000_0000, 1'b1, 60},
    '{4'd3,  32'h0000_0000, 1'b1, 80},
    '{4'd8,  32'hAAAA_AAAA, 1'b0, 180},
    '{4'd5,  32'h0000_0000, 1'b1, 80},
    '{4'd8,  32'h0000_0000, 1'b1, 120},
    '{4'd9,  32'h0000_0000, 1'b1, 60},
    '{4'd6,  32'h9876_5432, 1'b0, 60}
  };

  hex_grid_boundary_distance_unit u_top (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void rebuild_grid();
    int r, c, n, len;
    n = 0;
    if (row_count_sh == 4'd0) grid_rows = 1;
    else if (row_count_sh > ROWS) grid_rows = ROWS;
    else grid_rows = int'(row_count_sh);
    for (r = 0; r < grid_rows; r++) begin
      len = int'(row_lengths_sh[4*r +: 4]);
      if (len < 1) len = 1;
      if (len > ROW_CELLS) len = ROW_CELLS;
      row_len[r]  = len;
      row_base[r] = n;
      for (c = 0; c < len && n < CELLS; c++) begin
        cell_r[n] = r;
        cell_c[n] = c;
        n++;
      end
    end
    n_cells = n;
  endfunction

  function automatic int cell_at(int r, int c);
    int idx;
    if (r < 0 || r >= grid_rows) return -1;
    if (c < 0 || c >= row_len[r]) return -1;
    idx = row_base[r] + c;
    return (idx < n_cells) ? idx : -1;
  endfunction

  function automatic bit on_edge(int i);
    return cell_r[i] == 0 || cell_r[i] == grid_rows - 1 ||
           cell_c[i] == 0 || cell_c[i] == row_len[cell_r[i]] - 1;
  endfunction

  // Neighbor k (0..5) of cell i, or -1. Odd rows sit half a cell to the left.
  function automatic int hex_nb(int i, int k);
    int r, c, dc;
    r  = cell_r[i];
    c  = cell_c[i];
    dc = (r % 2 == 0) ? 0 : -1;
    case (k)
      0:       return cell_at(r - 1, c + dc);
      1:       return cell_at(r - 1, c + dc + 1);
      2:       return cell_at(r, c - 1);
      3:       return cell_at(r, c + 1);
      4:       return cell_at(r + 1, c + dc);
      default: return cell_at(r + 1, c + dc + 1);
    endcase
  endfunction

  function automatic void predict_escape(input logic [CELL_W-1:0] start,
                                         input logic [CELLS-1:0] wall,
                                         output status_t st,
                                         output logic [DIST_W-1:0] steps);
    logic [CELLS-1:0] seen, front, nxt;
    int s, lvl, i, k, nb;
    bit done, hit;
    s     = int'(start);
    st    = ST_ESCAPED;
    steps = '0;
    if (s >= n_cells) st = ST_INVALID;
    else if (wall[s]) st = ST_BLOCKED;
    else if (!on_edge(s)) begin
      // Running out of levels without touching the edge counts as enclosed.
      st    = ST_ENCLOSED;
      seen  = wall;
      seen[s] = 1'b1;
      front = '0;
      front[s] = 1'b1;
      done  = 1'b0;
      for (lvl = 1; lvl <= CELLS && !done; lvl++) begin
        nxt = '0;
        for (i = 0; i < n_cells; i++) begin
          if (front[i]) begin
            for (k = 0; k < 6; k++) begin
              nb = hex_nb(i, k);
              if (nb >= 0 && !seen[nb]) nxt[nb] = 1'b1;
            end
          end
        end
        hit = 1'b0;
        for (i = 0; i < n_cells; i++)
          if (nxt[i] && on_edge(i)) hit = 1'b1;
        if (hit) begin
          st    = ST_ESCAPED;
          steps = DIST_W'(lvl);
          done  = 1'b1;
        end else if (nxt == '0) begin
          done = 1'b1;
        end else begin
          seen  = seen | nxt;
          front = nxt;
        end
      end
    end
  endfunction

  // Idle length for one word, with occasional runs of back-to-back words.
  function automatic int draw_idle(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) calm = $urandom_range(4, 24);
    return $urandom_range(0, 12);
  endfunction

  task automatic report_mismatch(input string what);
    n_errors++;
    if (n_errors <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic send_word(input logic [CELL_W-1:0] start, input logic [CELLS-1:0] wall,
                           input bit known, input status_t st,
                           input logic [DIST_W-1:0] steps);
    int gap;
    gap = draw_idle(calm_in);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, wall, start};
    cur_known <= known;
    cur_st    <= st;
    cur_dist  <= steps;
    do @(posedge clk); while (!in_tready);
  endtask

  // Holds the input back until every outstanding result has come out.
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_escapes.size() != 0);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == REG_ROW_COUNT) row_count_sh = value[3:0];
    else row_lengths_sh = value;
    rebuild_grid();
    @(posedge clk);
  endtask

  // Mostly winding corridors carved out of a solid mask, so the search runs
  // many levels; the rest are masks of random density.
  task automatic random_word();
    logic [CELL_W-1:0] start;
    logic [CELLS-1:0]  wall;
    int s, cur, nb, flip, pct;
    if ($urandom_range(0, 19) == 0) s = $urandom_range(0, 127);
    else s = $urandom_range(0, n_cells - 1);
    start = CELL_W'(s);
    if ($urandom_range(0, 9) < 6) begin
      wall = ALL_WALLS;
      if (s < n_cells) begin
        cur = s;
        wall[cur] = 1'b0;
        repeat ($urandom_range(2, 60)) begin
          nb = hex_nb(cur, $urandom_range(0, 5));
          if (nb >= 0) begin
            cur = nb;
            wall[cur] = 1'b0;
          end
        end
      end
      if ($urandom_range(0, 2) == 0) begin
        flip = $urandom_range(0, CELLS - 1);
        wall[flip] = ~wall[flip];
      end
    end else begin
      case ($urandom_range(0, 5))
        0:       pct = 0;
        1:       pct = 15;
        2:       pct = 35;
        3:       pct = 50;
        4:       pct = 70;
        default: pct = 100;
      endcase
      for (int i = 0; i < CELLS; i++) wall[i] = ($urandom_range(0, 99) < pct);
      if (s < n_cells && $urandom_range(0, 4) != 0) wall[s] = 1'b0;
    end
    send_word(start, wall, 1'b0, ST_ESCAPED, '0);
  endtask

  always @(posedge clk) begin : take_in
    escape_t got;
    if (rst_n && in_tvalid && in_tready) begin
      words_in++;
      if (cur_known) begin
        got.st    = cur_st;
        got.steps = cur_dist;
      end else begin
        predict_escape(in_tdata[6:0], in_tdata[86:7], got.st, got.steps);
      end
      pending_escapes.insert(pending_escapes.size(), got);
    end
  end

  always @(posedge clk) begin : check_out
    escape_t want;
    if (rst_n && out_tvalid && out_tready) begin
      status_seen[out_tdata[1:0]]++;
      if (out_tdata[1:0] == ST_ESCAPED && int'(out_tdata[8:2]) > far_dist)
        far_dist = int'(out_tdata[8:2]);
      if (pending_escapes.size() == 0) begin
        report_mismatch("result word with no input outstanding");
      end else begin
        want = pending_escapes.pop_front();
        if (out_tdata[1:0] !== want.st)
          report_mismatch($sformatf("status %0d, predicted %0d", out_tdata[1:0], want.st));
        if (out_tdata[8:2] !== want.steps)
          report_mismatch($sformatf("distance %0d, predicted %0d", out_tdata[8:2],
                                    want.steps));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
                 (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : result_sink
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = draw_idle(calm_out);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && rst_n));
    end
  end

  initial begin : stimulus
    int k, p;
    row_count_sh   = ROW_COUNT_RST;
    row_lengths_sh = ROW_LENGTHS_RST;
    rebuild_grid();
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cur_known   <= 1'b0;
    cur_st      <= ST_ESCAPED;
    cur_dist    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < DIR_N; k++)
      send_word(dir_tab[k].start, dir_tab[k].wall, dir_tab[k].known, dir_tab[k].st,
                dir_tab[k].steps);

    for (p = 0; p < SETTING_N; p++) begin
      settle();
      write_reg(REG_ROW_COUNT, {28'd0, settings[p].rows});
      write_reg(REG_ROW_LENGTHS, settings[p].rnd_lens ? $urandom() : settings[p].lens);
      n_settings++;
      repeat (settings[p].words) random_word();
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d words over %0d grid settings, from one cell up to 80 cells.",
             words_in, n_settings);
    $display("Results: %0d escaped (farthest %0d steps), %0d blocked, %0d enclosed, %0d invalid.",
             status_seen[ST_ESCAPED], far_dist, status_seen[ST_BLOCKED],
             status_seen[ST_ENCLOSED], status_seen[ST_INVALID]);
    if (n_errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

/* hex_grid_boundary_distance_unit.f */
design/hgbd_pkg.sv
design/hex_grid_boundary_distance_unit.sv
design/hgbd_checker.sv
tb/testbench.sv
